>>> design/ugsd_pkg.sv
package ugsd_pkg;

  // Depth of the byte queue between the classifier and the sequencer.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QptrW      = $clog2(QueueDepth);
  localparam int unsigned QcntW      = $clog2(QueueDepth + 1);

  // Width of the configuration write data (the widest register).
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIndexW  = 3;

  // The ASCII space never has a glyph of its own.
  localparam logic [7:0] AsciiSpace  = 8'h20;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_START_X      = 3'd0,
    CFG_ROW_PAGE     = 3'd1,
    CFG_CHAR_GAP     = 3'd2,
    CFG_FONT_ENABLES = 3'd3,
    CFG_ASCII_FIRST  = 3'd4,
    CFG_ASCII_COUNT  = 3'd5,
    CFG_ASCII_WIDTH  = 3'd6,
    CFG_WIDE_WIDTH   = 3'd7
  } cfg_reg_e;

  // Kinds of character cell in a result.
  typedef enum logic [2:0] {
    KIND_ASCII_GLYPH = 3'd0,
    KIND_ASCII_NONE  = 3'd1,
    KIND_WIDE_CODE   = 3'd2,
    KIND_WIDE_NONE   = 3'd3,
    KIND_END         = 3'd4,
    KIND_IGNORED     = 3'd5
  } cell_kind_e;

  typedef struct packed {
    logic [15:0] start_x;
    logic [4:0]  row_page;
    logic [7:0]  char_gap;
    logic [1:0]  font_enables;
    logic [6:0]  ascii_first;
    logic [7:0]  ascii_count;
    logic [7:0]  ascii_width;
    logic [7:0]  wide_width;
  } cfg_t;

  // What the classifier learns about one byte outside a sequence.
  typedef struct packed {
    logic        is_end;
    logic        is_ascii;
    logic        has_glyph;
    logic [6:0]  glyph_index;
    logic        is_wide;
    logic        is_lead;
    logic [1:0]  seq_len;
    logic [20:0] lead_acc;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  text_byte;
    byte_class_t cls;
  } qent_t;

  // Classify one byte against the current font configuration.
  function automatic byte_class_t classify(logic [7:0] b, cfg_t cfg);
    byte_class_t c;
    logic [6:0]  idx;
    logic [2:0]  ones;
    c    = '0;
    idx  = b[6:0] - cfg.ascii_first;
    // Leading ones of the byte, counted up to five.
    if (!b[7]) begin
      ones = 3'd0;
    end else if (!b[6]) begin
      ones = 3'd1;
    end else if (!b[5]) begin
      ones = 3'd2;
    end else if (!b[4]) begin
      ones = 3'd3;
    end else if (!b[3]) begin
      ones = 3'd4;
    end else begin
      ones = 3'd5;
    end
    c.is_end      = (b == 8'h00);
    c.is_ascii    = cfg.font_enables[0] && !b[7];
    c.has_glyph   = (b != AsciiSpace) && (b[6:0] >= cfg.ascii_first) &&
                    ({1'b0, idx} < cfg.ascii_count);
    c.glyph_index = idx;
    c.is_wide     = cfg.font_enables[1];
    c.is_lead     = (ones >= 3'd2) && (ones <= 3'd4);
    c.seq_len     = 2'(ones - 3'd1);
    case (ones)
      3'd2:    c.lead_acc = {10'b0, b[4:0], 6'b0};
      3'd3:    c.lead_acc = {5'b0, b[3:0], 12'b0};
      3'd4:    c.lead_acc = {b[2:0], 18'b0};
      default: c.lead_acc = '0;
    endcase
    return c;
  endfunction

endpackage

>>> design/utf8_glyph_stream_decoder_top.sv
// Decodes a zero-terminated text string, one byte per request, into character cells
// with a running x position. Ordinary bytes are taken at one per cycle while the
// queue has room, and give at most one cell each via the queue and the result
// register. An end-of-string byte keeps the sequencer busy while it ends every
// sequence it cuts short and replays every held continuation byte; a four-entry
// byte queue in front of the sequencer keeps taking requests until full, and the
// one-entry result register is the only other buffering. Users write configuration
// through a plain write port while the block is idle; the block does not check it.
module utf8_glyph_stream_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ugsd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ugsd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     text_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     cell_kind_o,
  output logic [6:0]                     glyph_index_o,
  output logic [20:0]                    code_point_o,
  output logic [15:0]                    x_pos_o,
  output logic [4:0]                     page_row_o,
  output logic                           last_o
);

  ugsd_pkg::cfg_t  cfg_q;
  logic            q_valid;
  ugsd_pkg::qent_t q_entry;
  logic            q_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x      <= 16'd0;
      cfg_q.row_page     <= 5'd0;
      cfg_q.char_gap     <= 8'd0;
      cfg_q.font_enables <= 2'd3;
      cfg_q.ascii_first  <= 7'd32;
      cfg_q.ascii_count  <= 8'd95;
      cfg_q.ascii_width  <= 8'd8;
      cfg_q.wide_width   <= 8'd16;
    end else if (cfg_we_i) begin
      case (ugsd_pkg::cfg_reg_e'(cfg_index_i))
        ugsd_pkg::CFG_START_X:      cfg_q.start_x      <= cfg_wdata_i;
        ugsd_pkg::CFG_ROW_PAGE:     cfg_q.row_page     <= cfg_wdata_i[4:0];
        ugsd_pkg::CFG_CHAR_GAP:     cfg_q.char_gap     <= cfg_wdata_i[7:0];
        ugsd_pkg::CFG_FONT_ENABLES: cfg_q.font_enables <= cfg_wdata_i[1:0];
        ugsd_pkg::CFG_ASCII_FIRST:  cfg_q.ascii_first  <= cfg_wdata_i[6:0];
        ugsd_pkg::CFG_ASCII_COUNT:  cfg_q.ascii_count  <= cfg_wdata_i[7:0];
        ugsd_pkg::CFG_ASCII_WIDTH:  cfg_q.ascii_width  <= cfg_wdata_i[7:0];
        ugsd_pkg::CFG_WIDE_WIDTH:   cfg_q.wide_width   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Classifier and byte queue.
  ugsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .q_valid_o   (q_valid),
    .q_entry_o   (q_entry),
    .q_pop_i     (q_pop)
  );

  // Sequence decoder and result register.
  ugsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_kind_o   (cell_kind_o),
    .glyph_index_o (glyph_index_o),
    .code_point_o  (code_point_o),
    .x_pos_o       (x_pos_o),
    .page_row_o    (page_row_o),
    .last_o        (last_o)
  );

  // A request taken always leaves the queue non-empty in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> q_valid)
    else $error("accepted byte did not reach the queue");

  // The last flag marks the end-of-string cell and nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (cell_kind_o == ugsd_pkg::KIND_END)))
    else $error("last flag and end cell disagree");

  // Only a decoded wide cell carries a code point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cell_kind_o != ugsd_pkg::KIND_WIDE_CODE) |-> (code_point_o == '0))
    else $error("code point on a cell that is not a wide code");

  // Only an ASCII glyph cell carries a glyph index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cell_kind_o != ugsd_pkg::KIND_ASCII_GLYPH) |-> (glyph_index_o == '0))
    else $error("glyph index on a cell without an ASCII glyph");

endmodule

>>> design/ugsd_front.sv
module ugsd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ugsd_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           text_byte_i,
  output logic                 q_valid_o,
  output ugsd_pkg::qent_t      q_entry_o,
  input  logic                 q_pop_i
);

  ugsd_pkg::qent_t                  mem_q [ugsd_pkg::QueueDepth];
  logic [ugsd_pkg::QptrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ugsd_pkg::QptrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ugsd_pkg::QcntW-1:0]       cnt_q, cnt_d;
  logic                             push;
  ugsd_pkg::qent_t                  new_entry;

  // Classify the incoming byte before it is queued.
  always_comb begin
    new_entry.text_byte = text_byte_i;
    new_entry.cls       = ugsd_pkg::classify(text_byte_i, cfg_i);
  end

  // Queue control: the request is taken whenever a slot is free.
  assign in_stall_o = (cnt_q == ugsd_pkg::QcntW'(ugsd_pkg::QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule

>>> design/ugsd_back.sv
module ugsd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ugsd_pkg::cfg_t       cfg_i,
  input  logic                 q_valid_i,
  input  ugsd_pkg::qent_t      q_entry_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           cell_kind_o,
  output logic [6:0]           glyph_index_o,
  output logic [20:0]          code_point_o,
  output logic [15:0]          x_pos_o,
  output logic [4:0]           page_row_o,
  output logic                 last_o
);

  // Decoder state.
  logic [1:0]  seq_rem_q, seq_rem_d;
  logic [20:0] acc_q, acc_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [15:0] x_off_q, x_off_d;
  logic [7:0]  replay0_q, replay0_d, replay1_q, replay1_d;
  logic [1:0]  replay_cnt_q, replay_cnt_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  ugsd_pkg::cell_kind_e  out_kind_q;
  logic [6:0]            out_glyph_q;
  logic [20:0]           out_cp_q;
  logic [15:0]           out_x_q;
  logic [4:0]            out_page_q;
  logic                  out_last_q;

  // Step signals.
  logic                  src_replay, out_free, go;
  logic [7:0]            src_byte;
  ugsd_pkg::byte_class_t src_cls;
  logic [20:0]           cont_bits, acc_cont;
  logic [1:0]            rem_next;
  logic                  res_valid, res_last, adv_en;
  ugsd_pkg::cell_kind_e  res_kind;
  logic [6:0]            res_glyph;
  logic [20:0]           res_cp;
  logic [7:0]            adv_w;

  // Pick the byte for this step: a pending replay goes before the queue.
  always_comb begin
    src_replay = (replay_cnt_q != 2'd0);
    src_byte   = src_replay ? replay0_q : q_entry_i.text_byte;
    src_cls    = src_replay ? ugsd_pkg::classify(replay0_q, cfg_i) : q_entry_i.cls;
    out_free   = !out_valid_q || !out_stall_i;
    go         = out_free && (src_replay || q_valid_i);
  end

  // Continuation bits land at the place the remaining count selects.
  always_comb begin
    case (seq_rem_q)
      2'd1:    cont_bits = {15'b0, src_byte[5:0]};
      2'd2:    cont_bits = {9'b0, src_byte[5:0], 6'b0};
      2'd3:    cont_bits = {3'b0, src_byte[5:0], 12'b0};
      default: cont_bits = '0;
    endcase
  end

  assign acc_cont = acc_q | cont_bits;
  assign rem_next = seq_rem_q - 2'd1;

  // One step per cycle unless stalled: replayed byte, queued byte, or string-end step.
  always_comb begin
    seq_rem_d    = seq_rem_q;
    acc_d        = acc_q;
    held0_d      = held0_q;
    held1_d      = held1_q;
    held_cnt_d   = held_cnt_q;
    x_off_d      = x_off_q;
    replay0_d    = replay0_q;
    replay1_d    = replay1_q;
    replay_cnt_d = replay_cnt_q;

    q_pop_o      = 1'b0;
    res_valid    = 1'b0;
    res_kind     = ugsd_pkg::KIND_IGNORED;
    res_glyph    = '0;
    res_cp       = '0;
    res_last     = 1'b0;
    adv_en       = 1'b0;
    adv_w        = cfg_i.wide_width;

    if (go) begin
      if (src_replay) begin
        replay0_d    = replay1_q;
        replay_cnt_d = replay_cnt_q - 2'd1;
      end
      if (src_replay || !q_entry_i.cls.is_end) begin
        q_pop_o = !src_replay;
        if (seq_rem_q != 2'd0) begin
          // Continuation byte, taken unchecked.
          seq_rem_d = rem_next;
          if (rem_next != 2'd0) begin
            acc_d = acc_cont;
            if (held_cnt_q == 2'd0) begin
              held0_d    = src_byte;
              held_cnt_d = 2'd1;
            end else if (held_cnt_q == 2'd1) begin
              held1_d    = src_byte;
              held_cnt_d = 2'd2;
            end
          end else begin
            res_valid  = 1'b1;
            res_kind   = (acc_cont != '0) ? ugsd_pkg::KIND_WIDE_CODE
                                          : ugsd_pkg::KIND_WIDE_NONE;
            res_cp     = acc_cont;
            adv_en     = 1'b1;
            acc_d      = '0;
            held_cnt_d = 2'd0;
          end
        end else if (src_cls.is_ascii) begin
          res_valid = 1'b1;
          res_kind  = src_cls.has_glyph ? ugsd_pkg::KIND_ASCII_GLYPH
                                        : ugsd_pkg::KIND_ASCII_NONE;
          res_glyph = src_cls.has_glyph ? src_cls.glyph_index : 7'd0;
          adv_en    = 1'b1;
          adv_w     = cfg_i.ascii_width;
        end else if (src_cls.is_wide) begin
          if (src_cls.is_lead) begin
            acc_d      = src_cls.lead_acc;
            seq_rem_d  = src_cls.seq_len;
            held_cnt_d = 2'd0;
          end else begin
            res_valid = 1'b1;
            res_kind  = ugsd_pkg::KIND_WIDE_NONE;
            adv_en    = 1'b1;
          end
        end else begin
          res_valid = 1'b1;
          res_kind  = ugsd_pkg::KIND_IGNORED;
        end
      end else if (seq_rem_q != 2'd0) begin
        // String ended inside a sequence: drop the lead and replay the held bytes.
        res_valid    = 1'b1;
        res_kind     = ugsd_pkg::KIND_WIDE_NONE;
        adv_en       = 1'b1;
        replay0_d    = held0_q;
        replay1_d    = held1_q;
        replay_cnt_d = held_cnt_q;
        seq_rem_d    = 2'd0;
        acc_d        = '0;
        held_cnt_d   = 2'd0;
      end else begin
        // End of string.
        res_valid  = 1'b1;
        res_kind   = ugsd_pkg::KIND_END;
        res_last   = 1'b1;
        x_off_d    = '0;
        acc_d      = '0;
        held_cnt_d = 2'd0;
        q_pop_o    = 1'b1;
      end
      if (adv_en) begin
        x_off_d = x_off_q + 16'(adv_w) + 16'(cfg_i.char_gap);
      end
    end

    out_valid_d = out_free ? res_valid : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_rem_q    <= '0;
      acc_q        <= '0;
      held_cnt_q   <= '0;
      x_off_q      <= '0;
      replay_cnt_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      seq_rem_q    <= seq_rem_d;
      acc_q        <= acc_d;
      held_cnt_q   <= held_cnt_d;
      x_off_q      <= x_off_d;
      replay_cnt_q <= replay_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Held and replayed bytes, and the result payload.
  always_ff @(posedge clk_i) begin
    held0_q   <= held0_d;
    held1_q   <= held1_d;
    replay0_q <= replay0_d;
    replay1_q <= replay1_d;
    if (res_valid) begin
      out_kind_q  <= res_kind;
      out_glyph_q <= res_glyph;
      out_cp_q    <= res_cp;
      out_x_q     <= cfg_i.start_x + x_off_q;
      out_page_q  <= cfg_i.row_page;
      out_last_q  <= res_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_kind_o   = out_kind_q;
  assign glyph_index_o = out_glyph_q;
  assign code_point_o  = out_cp_q;
  assign x_pos_o       = out_x_q;
  assign page_row_o    = out_page_q;
  assign last_o        = out_last_q;

endmodule

>>> verif/tb_top.sv
import ugsd_pkg::*;

// One character cell as it leaves the block.
typedef struct packed {
  cell_kind_e  kind;
  logic [6:0]  glyph;
  logic [20:0] code;
  logic [15:0] x;
  logic [4:0]  page;
  logic        last;
} cell_t;

// Works out the cells that each accepted text byte must produce and keeps them in
// order until the block delivers them.
class cell_forecast;
  localparam int MaxCellsPerByte = 4;

  cfg_t        regs;
  logic [1:0]  seq_left;
  logic [20:0] code_acc;
  logic [7:0]  held [2];
  logic [1:0]  held_cnt;
  logic [15:0] x_off;
  int          step_cells;
  cell_t       due_cells [$];
  int unsigned mismatches;
  int unsigned cells_seen;
  int unsigned ends_seen;

  function new();
    regs = '{start_x: 16'd0, row_page: 5'd0, char_gap: 8'd0, font_enables: 2'd3,
             ascii_first: 7'd32, ascii_count: 8'd95, ascii_width: 8'd8,
             wide_width: 8'd16};
    seq_left   = '0;
    code_acc   = '0;
    held       = '{8'h00, 8'h00};
    held_cnt   = '0;
    x_off      = '0;
    mismatches = 0;
    cells_seen = 0;
    ends_seen  = 0;
  endfunction

  // Register writes are masked to the width of each register.
  function void set_reg(cfg_reg_e r, logic [15:0] v);
    case (r)
      CFG_START_X:      regs.start_x      = v;
      CFG_ROW_PAGE:     regs.row_page     = v[4:0];
      CFG_CHAR_GAP:     regs.char_gap     = v[7:0];
      CFG_FONT_ENABLES: regs.font_enables = v[1:0];
      CFG_ASCII_FIRST:  regs.ascii_first  = v[6:0];
      CFG_ASCII_COUNT:  regs.ascii_count  = v[7:0];
      CFG_ASCII_WIDTH:  regs.ascii_width  = v[7:0];
      CFG_WIDE_WIDTH:   regs.wide_width   = v[7:0];
    endcase
  endfunction

  // Queues one cell at the current position; a byte never yields more than four.
  function void add_cell(cell_kind_e k, logic [6:0] g, logic [20:0] cp, logic l);
    cell_t c;
    if (step_cells >= MaxCellsPerByte) return;
    c.kind  = k;
    c.glyph = g;
    c.code  = cp;
    c.x     = regs.start_x + x_off;
    c.page  = regs.row_page;
    c.last  = l;
    due_cells.push_back(c);
    step_cells++;
  endfunction

  function void step_x(logic [7:0] w);
    x_off = x_off + 16'(w) + 16'(regs.char_gap);
  endfunction

  // Handles one nonzero byte, either inside an open sequence or as a fresh byte.
  function void decode_byte(logic [7:0] b);
    logic [2:0] ones;
    int         idx;
    // Continuation bytes are merged unchecked while a sequence is open.
    if (seq_left != 0) begin
      code_acc = code_acc | (21'(b[5:0]) << (6 * (seq_left - 1)));
      seq_left = seq_left - 2'd1;
      if (seq_left != 0) begin
        if (held_cnt < 2) begin
          held[held_cnt] = b;
          held_cnt = held_cnt + 2'd1;
        end
        return;
      end
      if (code_acc != 0) add_cell(KIND_WIDE_CODE, 7'd0, code_acc, 1'b0);
      else add_cell(KIND_WIDE_NONE, 7'd0, 21'd0, 1'b0);
      step_x(regs.wide_width);
      code_acc = '0;
      held_cnt = '0;
      return;
    end
    // Plain ASCII with the ASCII font present.
    if (regs.font_enables[0] && !b[7]) begin
      idx = int'(b) - int'(regs.ascii_first);
      if (b != AsciiSpace && idx >= 0 && idx < int'(regs.ascii_count))
        add_cell(KIND_ASCII_GLYPH, 7'(idx), 21'd0, 1'b0);
      else
        add_cell(KIND_ASCII_NONE, 7'd0, 21'd0, 1'b0);
      step_x(regs.ascii_width);
      return;
    end
    // Everything else goes to the wide font, if there is one.
    if (regs.font_enables[1]) begin
      ones = 3'd0;
      while (ones < 3'd5 && b[3'd7 - ones]) ones = ones + 3'd1;
      if (ones >= 3'd2 && ones <= 3'd4) begin
        code_acc = 21'(b & (8'hFF >> (ones + 3'd1))) << (6 * (ones - 3'd1));
        seq_left = 2'(ones - 3'd1);
        held_cnt = '0;
      end else begin
        add_cell(KIND_WIDE_NONE, 7'd0, 21'd0, 1'b0);
        step_x(regs.wide_width);
      end
      return;
    end
    add_cell(KIND_IGNORED, 7'd0, 21'd0, 1'b0);
  endfunction

  // Called for every accepted text byte.
  function void note_byte(logic [7:0] b);
    logic [7:0] replay [2];
    int         cnt;
    step_cells = 0;
    if (b != 8'h00) begin
      decode_byte(b);
      return;
    end
    // A string cut short inside a sequence: the lead becomes an empty wide cell
    // and the held continuation bytes are taken again as fresh bytes.
    while (seq_left != 0) begin
      replay = held;
      cnt    = held_cnt;
      add_cell(KIND_WIDE_NONE, 7'd0, 21'd0, 1'b0);
      step_x(regs.wide_width);
      seq_left = '0;
      code_acc = '0;
      held_cnt = '0;
      for (int i = 0; i < cnt; i++) decode_byte(replay[i]);
    end
    add_cell(KIND_END, 7'd0, 21'd0, 1'b1);
    x_off    = '0;
    code_acc = '0;
    held_cnt = '0;
  endfunction

  task report_mismatch(string msg);
    if (mismatches < 40) $display("MISMATCH %s", msg);
    mismatches++;
  endtask

  task check_field(string name, logic [20:0] got, logic [20:0] want);
    if (got !== want)
      report_mismatch($sformatf("cell %0d %s: got %0d, expected %0d",
                                cells_seen, name, got, want));
  endtask

  // Compares a delivered cell with the oldest one still due.
  task check_cell(cell_t got);
    cell_t want;
    if (due_cells.size() == 0) begin
      report_mismatch($sformatf("cell of kind %0d at x %0d arrived with none due",
                                got.kind, got.x));
      return;
    end
    want = due_cells.pop_front();
    cells_seen++;
    if (want.kind == KIND_END) ends_seen++;
    check_field("cell_kind", got.kind, want.kind);
    check_field("glyph_index", got.glyph, want.glyph);
    check_field("code_point", got.code, want.code);
    check_field("x_pos", got.x, want.x);
    check_field("page_row", got.page, want.page);
    check_field("last", got.last, want.last);
  endtask
endclass

module tb_top;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainLimit   = 4000;
  localparam int unsigned SettleCycles = 20;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           text_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [2:0]           cell_kind_o;
  logic [6:0]           glyph_index_o;
  logic [20:0]          code_point_o;
  logic [15:0]          x_pos_o;
  logic [4:0]           page_row_o;
  logic                 last_o;

  cell_forecast cells;
  int unsigned  idle_pct;
  int unsigned  stall_pct;
  int unsigned  cycles = 0;
  int unsigned  bytes_sent = 0;

  utf8_glyph_stream_decoder_top dut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Give up if the block stops moving.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // The receiver holds off results at random.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Every cell taken by the receiver is checked.
  always @(posedge clk_i) begin : watch_cells
    cell_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind: cell_kind_e'(cell_kind_o), glyph: glyph_index_o,
              code: code_point_o, x: x_pos_o, page: page_row_o, last: last_o};
      cells.check_cell(got);
    end
  end

  // Writes one register; the enable stays high for a following write.
  task automatic write_reg(input cfg_reg_e r, input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_wdata_i <= v;
    cells.set_reg(r, v);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input cfg_t s);
    write_reg(CFG_START_X, s.start_x);
    write_reg(CFG_ROW_PAGE, 16'(s.row_page));
    write_reg(CFG_CHAR_GAP, 16'(s.char_gap));
    write_reg(CFG_FONT_ENABLES, 16'(s.font_enables));
    write_reg(CFG_ASCII_FIRST, 16'(s.ascii_first));
    write_reg(CFG_ASCII_COUNT, 16'(s.ascii_count));
    write_reg(CFG_ASCII_WIDTH, 16'(s.ascii_width));
    write_reg(CFG_WIDE_WIDTH, 16'(s.wide_width));
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t random_setting(input logic [1:0] fonts);
    cfg_t s;
    s.start_x      = 16'($urandom_range(0, 65535));
    s.row_page     = 5'($urandom_range(0, 31));
    s.char_gap     = 8'($urandom_range(0, 255));
    s.font_enables = fonts;
    s.ascii_first  = 7'($urandom_range(0, 127));
    s.ascii_count  = 8'($urandom_range(0, 128));
    s.ascii_width  = 8'($urandom_range(0, 255));
    s.wide_width   = 8'($urandom_range(0, 255));
    return s;
  endfunction

  // Offers one byte, idling first at random; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cells.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Mostly well-formed text with random content, some cut-off sequences and noise.
  task automatic send_random_text(input int n);
    int         sent;
    int         pick;
    int         len;
    int         conts;
    logic [7:0] lead;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_byte(8'($urandom_range(1, 127)));
        sent++;
      end else if (pick < 80) begin
        if (pick < 50) len = 2;
        else if (pick < 62) len = 3;
        else if (pick < 72) len = 4;
        else len = $urandom_range(2, 4);
        lead = 8'(8'hFF << (8 - len)) | 8'($urandom_range(0, 255) >> (len + 1));
        // Complete sequences, or truncated ones closed by the end of the string.
        conts = (pick < 72) ? len - 1 : $urandom_range(0, len - 2);
        send_byte(lead);
        sent++;
        for (int i = 0; i < conts; i++) begin
          send_byte(8'h80 | 8'($urandom_range(0, 63)));
          sent++;
        end
        if (pick >= 72) begin
          send_byte(8'h00);
          sent++;
        end
      end else if (pick < 90) begin
        send_byte(8'h00);
        sent++;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  // Waits for every due cell, then lets the block settle after bytes with no cell.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (cells.due_cells.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    if (cells.due_cells.size() != 0) begin
      cells.report_mismatch($sformatf("%0d expected cells never arrived",
                                      cells.due_cells.size()));
      cells.due_cells.delete();
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] opening [$];
    cfg_t       s;
    cells       = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_START_X;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    text_byte_i = '0;
    out_stall_i = 1'b0;
    idle_pct    = 9;
    stall_pct   = 77;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: glyph and no-glyph ASCII (letter, space, below the first
    // glyph, beyond the last), sequences of two, three and four bytes, a stray
    // continuation, a lead with five ones, an overlong zero, a string end, a
    // three-byte sequence cut short, and a cut-off whose replay opens a new one.
    opening = '{8'h41, 8'h20, 8'h1F, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hF8, 8'hC0, 8'h80, 8'h00,
                8'hE2, 8'h82, 8'h00, 8'hF0, 8'hF0, 8'h9F, 8'h00};
    foreach (opening[i]) send_byte(opening[i]);
    drain();

    // Upper extremes, with the position wrapping past 65535.
    s = '{start_x: 16'hFFF0, row_page: 5'd31, char_gap: 8'd255, font_enables: 2'd3,
          ascii_first: 7'd0, ascii_count: 8'd128, ascii_width: 8'd255,
          wide_width: 8'd255};
    apply_setting(s);
    send_random_text(40);
    drain();

    // Lower extremes with the ASCII font alone: no byte has a glyph.
    s = '{start_x: 16'h0000, row_page: 5'd0, char_gap: 8'd0, font_enables: 2'd1,
          ascii_first: 7'd127, ascii_count: 8'd0, ascii_width: 8'd0,
          wide_width: 8'd0};
    apply_setting(s);
    send_random_text(40);
    drain();

    // Sender slow, receiver quick.
    idle_pct  = 77;
    stall_pct = 9;
    apply_setting(random_setting(2'b10));
    send_random_text(40);
    drain();
    apply_setting(random_setting(2'b00));
    send_random_text(15);
    drain();

    // Neither side holds back.
    idle_pct  = 0;
    stall_pct = 0;
    apply_setting(random_setting(2'b11));
    send_random_text(50);
    drain();
    apply_setting(random_setting(2'b11));
    send_random_text(50);
    drain();

    $display("Sent %0d text bytes under the reset values and six register settings,",
             bytes_sent);
    $display("with stalls on either side and none; %0d cells compared, %0d string ends.",
             cells.cells_seen, cells.ends_seen);
    if (cells.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
design/ugsd_pkg.sv
design/ugsd_front.sv
design/ugsd_back.sv
design/utf8_glyph_stream_decoder_top.sv
verif/tb_top.sv
